// ===== sv/subocc_pkg.sv =====
package subocc_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int COUNT_W         = 32;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int LENREG_W        = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic               match_ends_here;
        logic [COUNT_W-1:0] match_count;
        logic               text_done;
    } t_out;

    typedef struct packed {
        logic       filled;
        logic [7:0] data;
    } t_link;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

// ===== sv/subocc_cell.sv =====
module subocc_cell
    import subocc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  t_link            i_link,
    input  logic [LEN_W-1:0] i_len,
    input  t_pattern         i_pattern,
    output t_link            o_link,
    output logic             o_match
);

    t_link            r_link;
    t_link            n_link;
    logic             w_use;
    logic [LEN_W-1:0] w_pos;
    logic [31:0]      w_pos_ext;
    logic [7:0]       w_pat_byte;

    // pattern byte aligned to this window slot: len-1-IDX
    always_comb begin
        w_use      = 32'(i_len) > 32'(IDX);
        w_pos      = i_len - LEN_W'(IDX) - LEN_W'(1);
        w_pos_ext  = 32'(w_pos);
        w_pat_byte = (w_pos_ext < 32'(PAT_BYTES)) ? i_pattern[w_pos_ext[3:0]] : 8'd0;
        o_match    = !w_use || (i_link.filled && (i_link.data == w_pat_byte));
    end

    always_comb begin
        n_link = r_link;
        if (i_ctrl.shift) begin
            if (i_ctrl.clear) begin
                n_link = '0;
            end else begin
                n_link = i_link;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

// ===== sv/subocc_counter.sv =====
module subocc_counter
    import subocc_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [MAX_PATTERN-1:0] i_match,
    input  logic                   i_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out                   o_out_data
);

    logic               r_valid;
    t_out               r_data;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               w_hit;
    logic               w_load;

    always_comb begin
        w_hit   = &i_match;
        o_ready = !r_valid || i_out_ready;
        w_load  = i_valid && o_ready;
        n_count = r_count;
        if (w_hit && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_count <= i_last ? '0 : n_count;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data.match_ends_here <= w_hit;
            r_data.match_count     <= n_count;
            r_data.text_done       <= i_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ===== sv/substring_occurrence_counter_core.sv =====
// Pipeline: a text byte's result is registered in the match stage and then in the count stage.
// Throughput: one byte per cycle; the window cell row and the count stage
// each take a new item whenever the stage behind them can move.
// Reset (synchronous, active low): window cells, fill marks and count clear;
// pattern registers clear and the pattern length returns to 1.
module substring_occurrence_counter_core
    import subocc_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [CFG_W-1:0]       r_pat_low;
    logic [CFG_W-1:0]       r_pat_high;
    logic [LENREG_W-1:0]    r_len;
    logic [LEN_W-1:0]       w_len;
    t_pattern               w_pattern;

    logic                   r_s1_valid;
    logic [MAX_PATTERN-1:0] r_s1_match;
    logic                   r_s1_last;
    logic                   w_s2_ready;
    logic                   w_accept;
    t_cell_ctrl             w_ctrl;
    t_link                  w_head;
    t_link                  w_link [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= LENREG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_len      <= i_cfg_data[LENREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_pattern = {r_pat_high, r_pat_low};
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_len) > 32'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = LEN_W'(r_len);
        end
    end

    assign o_in_ready   = !r_s1_valid || w_s2_ready;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_ctrl.shift = w_accept;
    assign w_ctrl.clear = i_in_data.last_byte;
    assign w_head       = '{filled: 1'b1, data: i_in_data.text_byte};

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        t_link w_cell_in;
        if (k == 0) begin : g_first
            assign w_cell_in = w_head;
        end else begin : g_next
            assign w_cell_in = w_link[k-1];
        end
        subocc_cell #(
            .IDX   (k),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_link    (w_cell_in),
            .i_len     (w_len),
            .i_pattern (w_pattern),
            .o_link    (w_link[k]),
            .o_match   (w_match[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_match <= w_match;
            r_s1_last  <= i_in_data.last_byte;
        end
    end

    subocc_counter #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_counter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .o_ready     (w_s2_ready),
        .i_match     (r_s1_match),
        .i_last      (r_s1_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.match_ends_here) |-> (o_out_data.match_count != '0))
        else $error("hit reported with zero count");

    a_last_clears_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.last_byte) |=> !w_link[0].filled)
        else $error("window not cleared after last byte");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && o_out_valid))
        else $error("input stalled with free stage");

endmodule
